// ----- design/assert_macros.svh -----
// Assertion helpers shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, skipped during reset.
`define BBD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same check, also held while reset is asserted.
`define BBD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/bbd_pkg.sv -----
// ----------------------------------------------------------------------------
// bbd_pkg
// Shared types, register indexes and color selection for the Bayer demosaic.
// ----------------------------------------------------------------------------
package bbd_pkg;

  localparam logic [1:0] CFG_IMAGE_WIDTH   = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [1:0] CFG_BAYER_PATTERN = 2'd2;

  // pending result bits
  localparam int PEND_WIN  = 0;
  localparam int PEND_EDGE = 1;
  localparam int PEND_BOT  = 2;

  typedef struct packed {
    logic [7:0]  sample;
    logic [11:0] row;
    logic [11:0] col;
    logic [11:0] edge_col;
    logic [11:0] bot_row;
    logic [1:0]  pattern;
    logic [2:0]  pend;
  } item_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } bgr_t;

  function automatic bgr_t window_color(input logic [7:0] w00, input logic [7:0] w01,
                                        input logic [7:0] w10, input logic [7:0] w11,
                                        input logic dr, input logic dc);
    bgr_t       res;
    logic [7:0] ga;
    logic [7:0] gb;
    logic [8:0] sum;
    case ({dr, dc})
      2'b00: begin
        res.red = w00; res.blue = w11; ga = w01; gb = w10;
      end
      2'b01: begin
        res.red = w01; res.blue = w10; ga = w00; gb = w11;
      end
      2'b10: begin
        res.red = w10; res.blue = w01; ga = w11; gb = w00;
      end
      default: begin
        res.red = w11; res.blue = w00; ga = w10; gb = w01;
      end
    endcase
    sum = {1'b0, ga} + {1'b0, gb} + 9'd1;
    res.green = sum[8:1];
    return res;
  endfunction

endpackage

// ----- design/bbd_line_mem.sv -----
// ----------------------------------------------------------------------------
// bbd_line_mem
// Previous-row line store: one read-first access per transfer.
// ----------------------------------------------------------------------------
module bbd_line_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          en,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      rdata     <= mem[addr];
      mem[addr] <= wdata;
    end
  end

endmodule

// ----- design/bbd_pos.sv -----
// ----------------------------------------------------------------------------
// bbd_pos
// Configuration registers, frame position counters and result planning.
// ----------------------------------------------------------------------------
module bbd_pos #(
  parameter int WIDTH_LIM = 4096
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [12:0]   cfg_data,
  input  logic          accept,
  input  logic [7:0]    raw_sample,
  output bbd_pkg::item_t item
);
  import bbd_pkg::*;

  localparam logic [12:0] W_LIM = 13'(WIDTH_LIM);
  localparam logic [12:0] H_LIM = 13'd4096;

  logic [12:0] image_width;
  logic [12:0] image_height;
  logic [1:0]  bayer_pattern;
  logic [11:0] row_count;
  logic [11:0] col_count;
  logic [12:0] w_eff;
  logic [12:0] h_eff;
  logic [11:0] w_last;
  logic [11:0] h_last;
  logic        cfg_hit;

  always_comb begin
    if (image_width < 13'd2) begin
      w_eff = 13'd2;
    end else if (image_width > W_LIM) begin
      w_eff = W_LIM;
    end else begin
      w_eff = image_width;
    end
    if (image_height < 13'd2) begin
      h_eff = 13'd2;
    end else if (image_height > H_LIM) begin
      h_eff = H_LIM;
    end else begin
      h_eff = image_height;
    end
  end

  assign w_last  = 12'(w_eff - 13'd1);
  assign h_last  = 12'(h_eff - 13'd1);
  assign cfg_hit = cfg_we && (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT ||
                              cfg_index == CFG_BAYER_PATTERN);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= 13'd640;
      image_height  <= 13'd480;
      bayer_pattern <= 2'd1;
      row_count     <= '0;
      col_count     <= '0;
    end else if (cfg_hit) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data;
        CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        default:          bayer_pattern <= cfg_data[1:0];
      endcase
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      if (col_count == w_last) begin
        col_count <= '0;
        row_count <= (row_count == h_last) ? 12'd0 : row_count + 12'd1;
      end else begin
        col_count <= col_count + 12'd1;
      end
    end
  end

  always_comb begin
    item.sample          = raw_sample;
    item.row             = row_count;
    item.col             = col_count;
    item.edge_col        = w_last;
    item.bot_row         = h_last;
    item.pattern         = bayer_pattern;
    item.pend[PEND_WIN]  = (row_count != 12'd0) && (col_count != 12'd0);
    item.pend[PEND_EDGE] = (row_count != 12'd0) && (col_count == w_last);
    item.pend[PEND_BOT]  = (row_count == h_last);
  end

endmodule

// ----- design/bbd_out.sv -----
// ----------------------------------------------------------------------------
// bbd_out
// Window stage and output register: builds each result and hands it out.
// ----------------------------------------------------------------------------
module bbd_out (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  bbd_pkg::item_t item_in,
  input  logic [7:0]     above,
  output logic           in_stall,
  output logic           accept,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [11:0]    pix_row,
  output logic [11:0]    pix_col,
  output logic [7:0]     blue_out,
  output logic [7:0]     green_out,
  output logic [7:0]     red_out,
  output logic           run_last
);
  import bbd_pkg::*;

  logic       a_valid;
  item_t      a_item;
  logic [2:0] pend;
  logic [2:0] pend_next;
  logic [7:0] prev_left;
  logic [7:0] prev_samp;
  logic       can_load;
  logic       load;
  logic       a_done;
  logic [11:0] r_row;
  logic [11:0] r_col;
  bgr_t       win_bgr;
  bgr_t       r_bgr;

  assign can_load  = !out_valid || !out_stall;
  assign pend_next = pend & (pend - 3'd1);
  assign load      = a_valid && (pend != 3'd0) && can_load;
  assign a_done    = a_valid && ((pend == 3'd0) || (can_load && pend_next == 3'd0));
  assign in_stall  = rst || (a_valid && !a_done);
  assign accept    = in_valid && !in_stall;

  assign win_bgr = window_color(prev_left, above, prev_samp, a_item.sample,
                                a_item.pattern[1] ^ ~a_item.row[0],
                                a_item.pattern[0] ^ ~a_item.col[0]);

  always_comb begin
    if (pend[PEND_WIN]) begin
      r_row = a_item.row - 12'd1;
      r_col = a_item.col - 12'd1;
      r_bgr = win_bgr;
    end else if (pend[PEND_EDGE]) begin
      r_row = a_item.row - 12'd1;
      r_col = a_item.edge_col;
      r_bgr = '0;
    end else begin
      r_row = a_item.bot_row;
      r_col = a_item.col;
      r_bgr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      pend      <= '0;
      prev_left <= '0;
      prev_samp <= '0;
    end else begin
      if (a_done) begin
        prev_left <= above;
        prev_samp <= a_item.sample;
      end
      if (accept) begin
        a_valid <= 1'b1;
        pend    <= item_in.pend;
      end else if (a_done) begin
        a_valid <= 1'b0;
        pend    <= '0;
      end else if (load) begin
        pend <= pend_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_item <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pix_row   <= r_row;
      pix_col   <= r_col;
      blue_out  <= r_bgr.blue;
      green_out <= r_bgr.green;
      red_out   <= r_bgr.red;
      run_last  <= (pend_next == 3'd0);
    end
  end

endmodule

// ----- design/bayer_to_bgr_demosaic.sv -----
// ----------------------------------------------------------------------------
// bayer_to_bgr_demosaic
// Streaming 2x2 Bayer demosaic producing BGR pixels with row and column.
// ----------------------------------------------------------------------------
// Input channel: one 8-bit raw sample per transfer (in_valid / in_stall), in
// raster order; the frame position is tracked inside the block.
// Output channel: one pixel per transfer (out_valid / out_stall) with its row,
// column and blue, green, red values; run_last marks the last pixel a sample
// produces. Row zero yields no pixel; column zero yields one only on the last row.
// Configuration: cfg_valid / cfg_ready write port, ready outside reset; index 0
// sets image_width, 1 image_height, 2 bayer_pattern. A write restarts the frame
// at row 0, column 0. Write only while the block is idle.
// Path: window stage, then output register. Throughput: one sample per cycle
// while the output is not stalled; a sample that yields two or three pixels
// (last column, last row) holds the input off until its last pixel loads.
// Reset loads 640 x 480, GRBG and clears the position; in_stall is high during
// reset. On an output stall the output register holds, and a sample in the
// window stage that still has pixels to emit holds the input off.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bayer_to_bgr_demosaic #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  raw_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] pix_row,
  output logic [11:0] pix_col,
  output logic [7:0]  blue_out,
  output logic [7:0]  green_out,
  output logic [7:0]  red_out,
  output logic        run_last
);
  import bbd_pkg::*;

  localparam int LINE_DEPTH = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;
  localparam int AW         = $clog2(LINE_DEPTH);

  item_t       item;
  logic        accept;
  logic        cfg_we;
  logic [7:0]  above;
  logic        cfg_restart;
  logic        out_held;
  logic [48:0] out_word;

  assign cfg_ready = !rst;
  assign cfg_we    = cfg_valid && cfg_ready;

  bbd_pos #(
    .WIDTH_LIM(LINE_DEPTH)
  ) u_pos (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .raw_sample(raw_sample),
    .item      (item)
  );

  bbd_line_mem #(
    .DEPTH(LINE_DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .en   (accept),
    .addr (AW'(item.col)),
    .wdata(raw_sample),
    .rdata(above)
  );

  bbd_out u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .item_in  (item),
    .above    (above),
    .in_stall (in_stall),
    .accept   (accept),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pix_row  (pix_row),
    .pix_col  (pix_col),
    .blue_out (blue_out),
    .green_out(green_out),
    .red_out  (red_out),
    .run_last (run_last)
  );

  assign cfg_restart = cfg_we && (cfg_index == CFG_IMAGE_WIDTH ||
                                  cfg_index == CFG_IMAGE_HEIGHT ||
                                  cfg_index == CFG_BAYER_PATTERN);
  assign out_held    = out_valid && out_stall;
  assign out_word    = {pix_row, pix_col, blue_out, green_out, red_out, run_last};

  `BBD_ASSERT(a_out_hold, clk, rst, out_held |=> out_valid && $stable(out_word), "held output changed")
  `BBD_ASSERT(a_cfg_restarts_frame, clk, rst, cfg_restart |=> item.col == 12'd0 && item.row == 12'd0, "no restart")
  `BBD_ASSERT(a_col_in_row, clk, rst, item.col <= item.edge_col, "column counter beyond the last column")
  `BBD_ASSERT_ALWAYS(a_reset_clears_out, clk, rst |=> !out_valid, "output valid after reset")

endmodule
